FILE: src/atc_pkg.sv
// ----------------------------------------------------------------------------
// atc_pkg: shared types and constants of the averaging thermostat controller
// Field widths, register map, reset values and the transaction structs that
// travel between the front, back and output parts.
// ----------------------------------------------------------------------------
package atc_pkg;

   localparam int TEMP_W   = 9;
   localparam int KIND_W   = 2;
   localparam int TICKS_W  = 16;

   localparam int WINDOW_LEN_DEF = 10;
   localparam int ADC_BITS_DEF   = 10;

   localparam logic [TEMP_W-1:0]  TEMP_MAX  = 9'd511;
   localparam logic [TEMP_W-1:0]  STEP      = 9'd5;
   localparam logic [TICKS_W-1:0] TICKS_MAX = 16'hFFFF;

   // register reset values
   localparam logic [TEMP_W-1:0]  MARGIN_RST           = 9'd5;
   localparam logic [TEMP_W-1:0]  MIN_SETPOINT_RST     = 9'd35;
   localparam logic [TEMP_W-1:0]  MAX_SETPOINT_RST     = 9'd75;
   localparam logic [TEMP_W-1:0]  INITIAL_SETPOINT_RST = 9'd60;
   localparam logic [TICKS_W-1:0] TIMEOUT_RST          = 16'd50;

   // configuration port
   localparam int REG_IDX_W  = 3;
   localparam int ADDR_W     = REG_IDX_W + 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_MARGIN           = 3'd0,
      REG_MIN_SETPOINT     = 3'd1,
      REG_MAX_SETPOINT     = 3'd2,
      REG_INITIAL_SETPOINT = 3'd3,
      REG_SETTING_TIMEOUT  = 3'd4
   } reg_index_type;

   // item kinds on the request channel
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UP     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DOWN   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd3;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_UP,
      OP_DOWN,
      OP_TICK
   } op_type;

   typedef enum logic {
      MODE_RUN = 1'b0,
      MODE_SET = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      LED_OFF    = 2'd0,
      LED_STEADY = 2'd1,
      LED_BLINK  = 2'd2
   } led_type;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      op_type            op;
      logic [TEMP_W-1:0] temp;
   } cmd_type;

   typedef struct packed {
      logic [TEMP_W-1:0]  margin;
      logic [TEMP_W-1:0]  min_setpoint;
      logic [TEMP_W-1:0]  max_setpoint;
      logic [TEMP_W-1:0]  initial_setpoint;
      logic [TICKS_W-1:0] setting_timeout;
   } cfg_type;

   typedef struct packed {
      mode_type          mode;
      logic [TEMP_W-1:0] setpoint;
      logic [TEMP_W-1:0] latest_temp;
   } snap_type;

   typedef struct packed {
      logic              mode;
      logic              heater_on;
      logic              cooler_on;
      led_type           led_mode;
      logic [TEMP_W-1:0] display_value;
      logic              display_blink;
      logic [TEMP_W-1:0] average_temp;
   } result_type;

endpackage

FILE: src/atc_front.sv
// ----------------------------------------------------------------------------
// atc_front: request intake and classification
// Decodes the item kind, halves and clamps the converter reading, and holds
// the classified commands in a short queue for the back part.
// ----------------------------------------------------------------------------
module atc_front #(
   parameter int ADC_BITS = atc_pkg::ADC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [atc_pkg::KIND_W-1:0]  req_kind,
   input  logic [ADC_BITS-1:0]         req_adc_value,
   output logic                        cmd_valid,
   output atc_pkg::cmd_type            cmd,
   input  logic                        cmd_take
);

   localparam int HALF_W = ADC_BITS + atc_pkg::TEMP_W;

   logic [HALF_W-1:0]                 half;
   atc_pkg::cmd_type                  cls;
   atc_pkg::cmd_type                  queue_ff [atc_pkg::QUEUE_DEPTH];
   logic [atc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [atc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [atc_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              push;
   logic                              pop;

   assign half = HALF_W'(req_adc_value) >> 1;

   always_comb begin
      cls.temp = (half > HALF_W'(atc_pkg::TEMP_MAX)) ? atc_pkg::TEMP_MAX
                                                      : half[atc_pkg::TEMP_W-1:0];
      case (req_kind)
         atc_pkg::KIND_SAMPLE: cls.op = atc_pkg::OP_SAMPLE;
         atc_pkg::KIND_UP:     cls.op = atc_pkg::OP_UP;
         atc_pkg::KIND_DOWN:   cls.op = atc_pkg::OP_DOWN;
         atc_pkg::KIND_TICK:   cls.op = atc_pkg::OP_TICK;
         default:              cls.op = atc_pkg::OP_TICK;
      endcase
   end

   assign req_stall = (count_ff == atc_pkg::QUEUE_CNT_W'(atc_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == atc_pkg::QUEUE_PTR_W'(atc_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == atc_pkg::QUEUE_PTR_W'(atc_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + atc_pkg::QUEUE_CNT_W'(push) - atc_pkg::QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: src/atc_back.sv
// ----------------------------------------------------------------------------
// atc_back: thermostat state update
// Carries out one queued command per cycle unless the output part holds off:
// ring and running sum upkeep in run mode, setpoint stepping and timeout in
// set mode, and registers a post-command state snapshot for the output part.
// ----------------------------------------------------------------------------
module atc_back #(
   parameter int WINDOW_LEN = atc_pkg::WINDOW_LEN_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  atc_pkg::cfg_type                                  cfg,
   input  logic                                              cmd_valid,
   input  atc_pkg::cmd_type                                  cmd,
   output logic                                              cmd_take,
   output logic                                              snap_valid,
   output atc_pkg::snap_type                                 snap,
   output logic [atc_pkg::TEMP_W+$clog2(WINDOW_LEN)-1:0]     snap_sum,
   input  logic                                              snap_ready
);

   localparam int SUM_W  = atc_pkg::TEMP_W + $clog2(WINDOW_LEN);
   localparam int SLOT_W = $clog2(WINDOW_LEN);
   localparam int TW     = atc_pkg::TEMP_W;

   atc_pkg::mode_type          mode_ff, mode_in;
   logic [TW-1:0]              setpoint_ff, setpoint_in;
   logic [atc_pkg::TICKS_W-1:0] ticks_ff, ticks_in, ticks_inc;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic                       primed_ff, primed_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [TW-1:0]              latest_ff, latest_in;
   logic [TW-1:0]              ring_ff [WINDOW_LEN];
   logic [TW-1:0]              ring_rd;
   logic [TW:0]                setpoint_up;
   logic                       pop;
   logic                       is_sample;
   logic                       fill_all;
   logic                       wr_one;
   logic                       snap_valid_ff;
   atc_pkg::snap_type          snap_ff;
   logic [SUM_W-1:0]           snap_sum_ff;

   assign cmd_take   = !snap_valid_ff || snap_ready;
   assign pop        = cmd_valid && cmd_take;
   assign is_sample  = pop && (mode_ff == atc_pkg::MODE_RUN) && (cmd.op == atc_pkg::OP_SAMPLE);
   assign fill_all   = is_sample && !primed_ff;
   assign wr_one     = is_sample && primed_ff;
   assign ring_rd    = ring_ff[slot_ff];
   assign ticks_inc  = (ticks_ff == atc_pkg::TICKS_MAX) ? ticks_ff : ticks_ff + 1'b1;
   assign setpoint_up = {1'b0, setpoint_ff} + {1'b0, atc_pkg::STEP};

   // mode sequencing
   always_comb begin
      mode_in = mode_ff;
      if (pop) begin
         case (mode_ff)
            atc_pkg::MODE_RUN: begin
               if (cmd.op inside {atc_pkg::OP_UP, atc_pkg::OP_DOWN}) begin
                  mode_in = atc_pkg::MODE_SET;
               end
            end
            atc_pkg::MODE_SET: begin
               if (cmd.op == atc_pkg::OP_TICK && ticks_inc >= cfg.setting_timeout) begin
                  mode_in = atc_pkg::MODE_RUN;
               end
            end
            default: mode_in = atc_pkg::MODE_RUN;
         endcase
      end
   end

   // datapath updates
   always_comb begin
      setpoint_in = setpoint_ff;
      ticks_in    = ticks_ff;
      slot_in     = slot_ff;
      primed_in   = primed_ff;
      sum_in      = sum_ff;
      latest_in   = latest_ff;
      if (pop) begin
         case (mode_ff)
            atc_pkg::MODE_RUN: begin
               case (cmd.op)
                  atc_pkg::OP_SAMPLE: begin
                     latest_in = cmd.temp;
                     if (!primed_ff) begin
                        // first sample fills the whole window
                        sum_in    = SUM_W'(cmd.temp) * SUM_W'(WINDOW_LEN);
                        slot_in   = '0;
                        primed_in = 1'b1;
                     end else begin
                        sum_in  = sum_ff - SUM_W'(ring_rd) + SUM_W'(cmd.temp);
                        slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0
                                                                        : slot_ff + 1'b1;
                     end
                  end
                  atc_pkg::OP_UP,
                  atc_pkg::OP_DOWN: ticks_in = '0;
                  default: ;
               endcase
            end
            atc_pkg::MODE_SET: begin
               case (cmd.op)
                  atc_pkg::OP_UP: begin
                     if (setpoint_ff < cfg.max_setpoint) begin
                        setpoint_in = (setpoint_up > {1'b0, atc_pkg::TEMP_MAX})
                                      ? atc_pkg::TEMP_MAX : setpoint_up[TW-1:0];
                     end
                     ticks_in = '0;
                  end
                  atc_pkg::OP_DOWN: begin
                     if (setpoint_ff > cfg.min_setpoint) begin
                        setpoint_in = (setpoint_ff >= atc_pkg::STEP)
                                      ? setpoint_ff - atc_pkg::STEP : '0;
                     end
                     ticks_in = '0;
                  end
                  atc_pkg::OP_TICK: begin
                     ticks_in = (ticks_inc >= cfg.setting_timeout) ? '0 : ticks_inc;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= atc_pkg::MODE_RUN;
         setpoint_ff   <= atc_pkg::INITIAL_SETPOINT_RST;
         ticks_ff      <= '0;
         slot_ff       <= '0;
         primed_ff     <= 1'b0;
         sum_ff        <= '0;
         latest_ff     <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         setpoint_ff <= setpoint_in;
         ticks_ff    <= ticks_in;
         slot_ff     <= slot_in;
         primed_ff   <= primed_in;
         sum_ff      <= sum_in;
         latest_ff   <= latest_in;
         if (cmd_take) begin
            snap_valid_ff <= cmd_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (fill_all || (wr_one && slot_ff == SLOT_W'(i))) begin
            ring_ff[i] <= cmd.temp;
         end
      end
      if (pop) begin
         snap_ff.mode        <= mode_in;
         snap_ff.setpoint    <= setpoint_in;
         snap_ff.latest_temp <= latest_in;
         snap_sum_ff         <= sum_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;
   assign snap_sum   = snap_sum_ff;

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(WINDOW_LEN - 1))
      else $error("write slot beyond window");

   a_press_enters_set: assert property (@(posedge clock) disable iff (reset)
      pop && mode_ff == atc_pkg::MODE_RUN &&
      (cmd.op == atc_pkg::OP_UP || cmd.op == atc_pkg::OP_DOWN)
      |=> mode_ff == atc_pkg::MODE_SET)
      else $error("press in run mode did not enter set mode");

   a_primed_sticky: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("ring lost its primed flag");

   a_setpoint_hold: assert property (@(posedge clock) disable iff (reset)
      !(pop && mode_ff == atc_pkg::MODE_SET) |=> $stable(setpoint_ff))
      else $error("setpoint moved outside set mode");

   a_sum_before_prime: assert property (@(posedge clock) disable iff (reset)
      !primed_ff |-> sum_ff == '0)
      else $error("running sum nonzero before first sample");

endmodule

FILE: src/atc_out.sv
// ----------------------------------------------------------------------------
// atc_out: averaging and heat/cool decision
// Divides the running sum by the window length through a reciprocal multiply,
// then compares the setpoint with the dead band and registers the result.
// ----------------------------------------------------------------------------
module atc_out #(
   parameter int WINDOW_LEN = atc_pkg::WINDOW_LEN_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic [atc_pkg::TEMP_W-1:0]                        margin,
   input  logic                                              snap_valid,
   input  atc_pkg::snap_type                                 snap,
   input  logic [atc_pkg::TEMP_W+$clog2(WINDOW_LEN)-1:0]     snap_sum,
   output logic                                              snap_ready,
   output logic                                              rsp_valid,
   input  logic                                              rsp_stall,
   output atc_pkg::result_type                               result
);

   localparam int TW        = atc_pkg::TEMP_W;
   localparam int SUM_W     = TW + $clog2(WINDOW_LEN);
   localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW_LEN);
   localparam int RECIP_W   = SUM_W + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   // exact for every sum below 2**SUM_W
   localparam int RECIP     = ((1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;

   logic [PROD_W-1:0]    product;
   logic                 a_valid_ff;
   atc_pkg::snap_type    a_snap_ff;
   logic [TW-1:0]        a_avg_ff;
   logic                 a_ready;
   logic                 b_ready;
   logic [TW:0]          avg_plus_margin;
   logic [TW:0]          setpoint_plus_margin;
   logic                 cool_side;
   logic                 heat_side;
   atc_pkg::result_type  res_in;
   atc_pkg::result_type  res_ff;
   logic                 rsp_valid_ff;

   assign product    = PROD_W'(snap_sum) * PROD_W'(RECIP);
   assign b_ready    = !rsp_valid_ff || !rsp_stall;
   assign a_ready    = !a_valid_ff || b_ready;
   assign snap_ready = a_ready;

   // setpoint against mean plus or minus margin, kept unsigned
   assign avg_plus_margin      = {1'b0, a_avg_ff} + {1'b0, margin};
   assign setpoint_plus_margin = {1'b0, a_snap_ff.setpoint} + {1'b0, margin};
   assign cool_side            = {1'b0, a_snap_ff.setpoint} < avg_plus_margin;
   assign heat_side            = setpoint_plus_margin > {1'b0, a_avg_ff};

   always_comb begin
      res_in.mode          = (a_snap_ff.mode == atc_pkg::MODE_SET);
      res_in.display_blink = (a_snap_ff.mode == atc_pkg::MODE_SET);
      res_in.display_value = (a_snap_ff.mode == atc_pkg::MODE_SET)
                             ? a_snap_ff.setpoint : a_snap_ff.latest_temp;
      res_in.average_temp  = a_avg_ff;
      res_in.heater_on     = 1'b0;
      res_in.cooler_on     = 1'b0;
      res_in.led_mode      = atc_pkg::LED_OFF;
      if (a_snap_ff.mode == atc_pkg::MODE_RUN) begin
         if (cool_side && !heat_side) begin
            res_in.cooler_on = 1'b1;
            res_in.led_mode  = atc_pkg::LED_STEADY;
         end else if (heat_side && !cool_side) begin
            res_in.heater_on = 1'b1;
            res_in.led_mode  = atc_pkg::LED_BLINK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= snap_valid;
         end
         if (b_ready) begin
            rsp_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (snap_valid && a_ready) begin
         a_snap_ff <= snap;
         a_avg_ff  <= product[AVG_SHIFT +: TW];
      end
      if (a_valid_ff && b_ready) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = res_ff;

endmodule

FILE: src/averaging_thermostat_controller.sv
// ----------------------------------------------------------------------------
// averaging_thermostat_controller: moving-average bang-bang thermostat
// Request channel (req_valid/req_stall) carries one item per transaction:
// a converter sample, an up or down press, or a time tick. Every accepted
// transaction yields exactly one result on the rsp_ channel, in order, with
// the mode, heater and cooler drive, led mode, display value and blink, and
// the truncated mean of the sample window.
// A request passes the command queue and the snapshot, averaging and output
// registers on its way to rsp_valid. One transaction per cycle is sustained
// while rsp_stall is low: the back part updates all state as it takes each
// command and the mean comes from a registered reciprocal multiply stage.
// A 2-entry queue parts intake from state update; req_stall rises only when
// it is full, behind held output, averaging and snapshot registers.
// Reset (synchronous, active high) clears all control state, loads register
// reset values and sets the setpoint to 60; no clearing pass is needed.
// The csr_ port is APB-style with pready tied high; registers sit at 4*index
// and must be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module averaging_thermostat_controller #(
   parameter int WINDOW_LEN = atc_pkg::WINDOW_LEN_DEF,
   parameter int ADC_BITS   = atc_pkg::ADC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [atc_pkg::KIND_W-1:0]        req_kind,
   input  logic [ADC_BITS-1:0]               req_adc_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_mode,
   output logic                              rsp_heater_on,
   output logic                              rsp_cooler_on,
   output logic [1:0]                        rsp_led_mode,
   output logic [atc_pkg::TEMP_W-1:0]        rsp_display_value,
   output logic                              rsp_display_blink,
   output logic [atc_pkg::TEMP_W-1:0]        rsp_average_temp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [atc_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [atc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [atc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int SUM_W = atc_pkg::TEMP_W + $clog2(WINDOW_LEN);

   atc_pkg::cfg_type                 cfg_ff;
   logic                             csr_write;
   logic [atc_pkg::REG_IDX_W-1:0]    csr_index;
   logic                             cmd_valid;
   atc_pkg::cmd_type                 cmd;
   logic                             cmd_take;
   logic                             snap_valid;
   atc_pkg::snap_type                snap;
   logic [SUM_W-1:0]                 snap_sum;
   logic                             snap_ready;
   atc_pkg::result_type              result;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[atc_pkg::ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.margin           <= atc_pkg::MARGIN_RST;
         cfg_ff.min_setpoint     <= atc_pkg::MIN_SETPOINT_RST;
         cfg_ff.max_setpoint     <= atc_pkg::MAX_SETPOINT_RST;
         cfg_ff.initial_setpoint <= atc_pkg::INITIAL_SETPOINT_RST;
         cfg_ff.setting_timeout  <= atc_pkg::TIMEOUT_RST;
      end else if (csr_write) begin
         case (csr_index)
            atc_pkg::REG_MARGIN:
               cfg_ff.margin <= csr_pwdata[atc_pkg::TEMP_W-1:0];
            atc_pkg::REG_MIN_SETPOINT:
               cfg_ff.min_setpoint <= csr_pwdata[atc_pkg::TEMP_W-1:0];
            atc_pkg::REG_MAX_SETPOINT:
               cfg_ff.max_setpoint <= csr_pwdata[atc_pkg::TEMP_W-1:0];
            atc_pkg::REG_INITIAL_SETPOINT:
               cfg_ff.initial_setpoint <= csr_pwdata[atc_pkg::TEMP_W-1:0];
            atc_pkg::REG_SETTING_TIMEOUT:
               cfg_ff.setting_timeout <= csr_pwdata[atc_pkg::TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         atc_pkg::REG_MARGIN:
            csr_prdata = atc_pkg::CSR_DATA_W'(cfg_ff.margin);
         atc_pkg::REG_MIN_SETPOINT:
            csr_prdata = atc_pkg::CSR_DATA_W'(cfg_ff.min_setpoint);
         atc_pkg::REG_MAX_SETPOINT:
            csr_prdata = atc_pkg::CSR_DATA_W'(cfg_ff.max_setpoint);
         atc_pkg::REG_INITIAL_SETPOINT:
            csr_prdata = atc_pkg::CSR_DATA_W'(cfg_ff.initial_setpoint);
         atc_pkg::REG_SETTING_TIMEOUT:
            csr_prdata = atc_pkg::CSR_DATA_W'(cfg_ff.setting_timeout);
         default:
            csr_prdata = '0;
      endcase
   end

   atc_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_adc_value (req_adc_value),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   atc_back #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_take   (cmd_take),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_sum   (snap_sum),
      .snap_ready (snap_ready)
   );

   atc_out #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .margin     (cfg_ff.margin),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_sum   (snap_sum),
      .snap_ready (snap_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .result     (result)
   );

   assign rsp_mode          = result.mode;
   assign rsp_heater_on     = result.heater_on;
   assign rsp_cooler_on     = result.cooler_on;
   assign rsp_led_mode      = result.led_mode;
   assign rsp_display_value = result.display_value;
   assign rsp_display_blink = result.display_blink;
   assign rsp_average_temp  = result.average_temp;

endmodule
